// ----- sv/pssm_pkg.sv -----
// shared types and constants for the polygon scanline span midpoint unit
package pssm_pkg;

  localparam int MaxVerticesDef = 16;
  localparam int TolW = 25;
  localparam logic [TolW-1:0] TolReset = 25'd17;
  // magnitude limit of the interpolation quotient
  localparam logic [63:0] QLimit = 64'h100_0000_0000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CONVEX = 2'd3
  } op_t;

  localparam logic [0:0] REG_SPAN_TOL = 1'b0;
  localparam logic [0:0] REG_FLAT_TOL = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic clear;      // vertex count to zero
    logic append;     // write vertex
    logic rd_first;   // issue read of last vertex (prev of edge 0)
    logic rd_next;    // issue read of current edge end
    logic edge_eval;  // evaluate edge from read data
    logic div_start;  // start divider
    logic div_done;   // fold divider result
    logic finish;     // build result word
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // no vertices
    logic last_edge;  // current edge is the last one
    logic need_div;   // evaluated edge needs interpolation
    logic div_busy;
    logic reject;     // convex test already failed
  } sts_t;

endpackage

// ----- sv/pssm_div.sv -----
// serial unsigned divider, one quotient bit per cycle
module pssm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] sh;
  logic [32:0] diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    sh = {rem_r[31:0], q_r[63]};
    diff = sh - {1'b0, dvs_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (!diff[32]) begin
        rem_nxt = diff;
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != 7'd0);
  assign quotient = q_r;
endmodule

// ----- sv/pssm_ctrl.sv -----
// controller state machine sequencing operations and the edge walk
module pssm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output pssm_pkg::ctl_t ctl,
  input  pssm_pkg::sts_t sts
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDF   = 9'b000000010,
    S_RDN   = 9'b000000100,
    S_WAIT  = 9'b000001000,
    S_EVAL  = 9'b000010000,
    S_DIVS  = 9'b000100000,
    S_DIVW  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          op_nxt = in_op;
          case (pssm_pkg::op_t'(in_op))
            pssm_pkg::OP_CLEAR, pssm_pkg::OP_APPEND: state_nxt = S_FIN;
            default: state_nxt = sts.empty ? S_FIN : S_RDF;
          endcase
        end
      end
      S_RDF: begin
        ctl.rd_first = 1'b1;
        state_nxt = S_RDN;
      end
      S_RDN: begin
        ctl.rd_next = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        ctl.edge_eval = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        if (sts.need_div) begin
          ctl.div_start = 1'b1;
          state_nxt = S_DIVW;
        end else if (sts.last_edge || sts.reject) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RDN;
        end
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          ctl.div_done = 1'b1;
          state_nxt = sts.last_edge ? S_FIN : S_RDN;
        end
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        if (pssm_pkg::op_t'(op_r) == pssm_pkg::OP_CLEAR) ctl.clear = 1'b1;
        if (pssm_pkg::op_t'(op_r) == pssm_pkg::OP_APPEND) ctl.append = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= '0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end
endmodule

// ----- sv/pssm_dp.sv -----
// datapath: vertex memory, edge evaluation, crossing span and convex test
module pssm_dp #(
  parameter int MAX_VERTICES = pssm_pkg::MaxVerticesDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pssm_pkg::ctl_t            ctl,
  output pssm_pkg::sts_t            sts,
  input  logic [1:0]                in_op,
  input  logic signed [31:0]        in_coord_x,
  input  logic signed [31:0]        in_coord_y,
  input  logic                      in_axis,
  input  logic [pssm_pkg::TolW-1:0] span_tol,
  input  logic [pssm_pkg::TolW-1:0] flat_tol,
  output logic signed [31:0]        out_midpoint,
  output logic                      out_found,
  output logic                      out_inside_res,
  output logic                      out_store_full
);
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [63:0] mem [MAX_VERTICES];
  logic [63:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic rd_en;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;  // index of current edge end
  logic [1:0] op_r;
  logic signed [31:0] px_r, py_r;
  logic axis_r;

  logic signed [31:0] k0_r, d0_r;   // previous vertex (key / along)
  logic signed [31:0] x0_r, y0_r;
  logic signed [63:0] hi_r, lo_r, hi_nxt, lo_nxt;
  logic any_r, any_nxt;
  logic ok_r, ok_nxt;
  logic need_div_r, need_div_nxt;
  logic neg_r, neg_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic signed [63:0] dbase_r, dbase_nxt;
  logic first_r, first_nxt;  // first read is the closing vertex

  logic signed [31:0] midpoint_r;
  logic found_r, inside_r, full_r;

  // current vertex fields
  logic signed [31:0] vx, vy, k1, d1, keyv;
  logic signed [33:0] ka, kdiff, ddiff, kmin_w, kmax_w, keyw;
  logic [32:0] dk_mag, a_mag, b_mag;
  logic hit, flat;
  logic signed [33:0] cx1, cy1, cdx, cdy;
  logic [63:0] m1, m2, ma, mb;
  logic n1, n2, gt;
  logic div_busy;
  logic [63:0] quot, qcl;
  logic signed [63:0] xing;
  logic signed [64:0] ssum, mid_w;

  assign vx = rd_r[63:32];
  assign vy = rd_r[31:0];
  assign k1 = axis_r ? vx : vy;
  assign d1 = axis_r ? vy : vx;
  assign keyv = axis_r ? px_r : py_r;

  always_comb begin
    keyw = 34'(keyv);
    kdiff = 34'(k1) - 34'(k0_r);
    ddiff = 34'(d1) - 34'(d0_r);
    ka = keyw - 34'(k0_r);
    kmin_w = (k0_r < k1) ? 34'(k0_r) : 34'(k1);
    kmax_w = (k0_r < k1) ? 34'(k1) : 34'(k0_r);
    hit = (keyw >= kmin_w - $signed(34'(span_tol))) &&
          (keyw <= kmax_w + $signed(34'(span_tol)));
    dk_mag = kdiff[33] ? 33'(-kdiff) : 33'(kdiff);
    a_mag = ka[33] ? 33'(-ka) : 33'(ka);
    b_mag = ddiff[33] ? 33'(-ddiff) : 33'(ddiff);
    flat = (dk_mag == '0) || (dk_mag < 33'(flat_tol));
    // convex test operands
    cx1 = 34'(px_r) - 34'(x0_r);
    cy1 = 34'(py_r) - 34'(y0_r);
    cdx = 34'(vx) - 34'(x0_r);
    cdy = 34'(vy) - 34'(y0_r);
    ma = 64'(cx1[33] ? 33'(-cx1) : 33'(cx1)) * 64'(cdy[33] ? 33'(-cdy) : 33'(cdy));
    mb = 64'(cy1[33] ? 33'(-cy1) : 33'(cy1)) * 64'(cdx[33] ? 33'(-cdx) : 33'(cdx));
    m1 = ma;
    m2 = mb;
    n1 = (m1 != '0) && (cx1[33] != cdy[33]);
    n2 = (m2 != '0) && (cy1[33] != cdx[33]);
    if (n1 != n2) gt = n2;
    else gt = n1 ? (m1 < m2) : (m1 > m2);
  end

  pssm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
    .dividend(dvd_r), .divisor(dvs_r), .busy(div_busy), .quotient(quot)
  );

  assign qcl = (quot > pssm_pkg::QLimit) ? pssm_pkg::QLimit : quot;
  assign xing = (neg_r && qcl != '0) ? dbase_r - $signed(qcl) : dbase_r + $signed(qcl);

  // memory read address
  always_comb begin
    rd_en = ctl.rd_first || ctl.rd_next;
    if (ctl.rd_first) rd_addr = AW'(cnt_r - CW'(1));
    else rd_addr = AW'(idx_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.append && (cnt_r < CW'(MAX_VERTICES))) mem[AW'(cnt_r)] <= {px_r, py_r};
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    any_nxt = any_r;
    ok_nxt = ok_r;
    need_div_nxt = need_div_r;
    neg_nxt = neg_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    dbase_nxt = dbase_r;
    first_nxt = first_r;
    if (ctl.load) begin
      idx_nxt = '0;
      any_nxt = 1'b0;
      ok_nxt = 1'b1;
      first_nxt = 1'b1;
      need_div_nxt = 1'b0;
    end
    if (ctl.clear) cnt_nxt = '0;
    if (ctl.append && (cnt_r < CW'(MAX_VERTICES))) cnt_nxt = cnt_r + CW'(1);
    if (ctl.rd_next) begin
      idx_nxt = idx_r + CW'(1);
      first_nxt = 1'b0;
    end
    if (ctl.edge_eval) begin
      need_div_nxt = 1'b0;
      if (op_r == pssm_pkg::OP_QUERY) begin
        if (hit) begin
          if (flat) begin
            if (!any_r || ((d0_r > d1 ? d0_r : d1) > hi_r))
              hi_nxt = 64'(d0_r > d1 ? d0_r : d1);
            if (!any_r || ((d0_r < d1 ? d0_r : d1) < lo_r))
              lo_nxt = 64'(d0_r < d1 ? d0_r : d1);
            any_nxt = 1'b1;
          end else begin
            need_div_nxt = 1'b1;
            dvd_nxt = 64'(a_mag) * 64'(b_mag);
            dvs_nxt = 32'(dk_mag);
            neg_nxt = (ka[33] != ddiff[33]) != kdiff[33];
            dbase_nxt = 64'(d0_r);
          end
        end
      end else if (gt) begin
        ok_nxt = 1'b0;
      end
    end
    if (ctl.div_start) need_div_nxt = 1'b0;
    if (ctl.div_done) begin
      if (!any_r || xing > hi_r) hi_nxt = xing;
      if (!any_r || xing < lo_r) lo_nxt = xing;
      any_nxt = 1'b1;
    end
  end

  always_comb begin
    ssum = 65'(hi_r) + 65'(lo_r);
    mid_w = ssum >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    idx_r <= idx_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    any_r <= any_nxt;
    ok_r <= ok_nxt;
    need_div_r <= need_div_nxt;
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    dbase_r <= dbase_nxt;
    first_r <= first_nxt;
    if (ctl.load) begin
      op_r <= in_op;
      px_r <= in_coord_x;
      py_r <= in_coord_y;
      axis_r <= in_axis;
    end
    // previous vertex follows the read stream after each evaluation
    if (ctl.edge_eval || (first_r && ctl.rd_next)) begin
      k0_r <= k1;
      d0_r <= d1;
      x0_r <= vx;
      y0_r <= vy;
    end
    if (ctl.finish) begin
      midpoint_r <= '0;
      found_r <= 1'b0;
      inside_r <= 1'b0;
      full_r <= 1'b0;
      case (pssm_pkg::op_t'(op_r))
        pssm_pkg::OP_APPEND: full_r <= (cnt_r >= CW'(MAX_VERTICES));
        pssm_pkg::OP_QUERY: begin
          if (any_r) begin
            found_r <= 1'b1;
            if (mid_w > 65'sd2147483647) midpoint_r <= 32'h7fff_ffff;
            else if (mid_w < -65'sd2147483648) midpoint_r <= 32'h8000_0000;
            else midpoint_r <= mid_w[31:0];
          end
        end
        pssm_pkg::OP_CONVEX: inside_r <= ok_r;
        default: ;
      endcase
    end
  end

  assign sts.empty = (cnt_r == '0);
  assign sts.last_edge = (idx_r == cnt_r);
  assign sts.need_div = need_div_r;
  assign sts.div_busy = div_busy;
  assign sts.reject = (op_r == pssm_pkg::OP_CONVEX) && !ok_r;

  assign out_midpoint = midpoint_r;
  assign out_found = found_r;
  assign out_inside_res = inside_r;
  assign out_store_full = full_r;
endmodule

// ----- sv/polygon_scanline_span_midpoint_unit.sv -----
// top level of the polygon scanline span midpoint unit
// usage:
//   input channel (in_valid/in_ready) takes one word: op, coord_x, coord_y,
//   axis. op clear empties the polygon, append stores a vertex (dropped with
//   store_full when the store is full), query returns the midpoint of the
//   crossing span on the scan key, convex reports whether the point lies in
//   or on a convex polygon.
//   result channel (out_valid/out_ready) gives one word per input word.
//   configuration port (APB style, always ready) holds span_tolerance at
//   byte address 0 and flat_tolerance at byte address 4, both reset to 17.
// timing:
//   one word at a time. clear and append go from the accepting state
//   through the finish state to the result register.
//   a query reads the closing vertex, then for each edge reads, waits,
//   evaluates and, where the edge needs interpolation, runs it through the
//   serial 64-step divider. convex test walks the edges without the divider
//   and stops at the first rejecting edge.
//   a result word holds in its register until out_ready; the next input
//   is taken once the result has gone.
// reset:
//   rst_n synchronously empties the polygon and restores tolerances.
module polygon_scanline_span_midpoint_unit #(
  parameter int MAX_VERTICES = pssm_pkg::MaxVerticesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic               in_axis,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_midpoint,
  output logic               out_found,
  output logic               out_inside_res,
  output logic               out_store_full,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic [pssm_pkg::TolW-1:0] span_tol_r, flat_tol_r;
  pssm_pkg::ctl_t ctl;
  pssm_pkg::sts_t sts;
  logic [0:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[2];

  // register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_tol_r <= pssm_pkg::TolReset;
      flat_tol_r <= pssm_pkg::TolReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (reg_sel == pssm_pkg::REG_SPAN_TOL) span_tol_r <= cfg_pwdata[pssm_pkg::TolW-1:0];
      else flat_tol_r <= cfg_pwdata[pssm_pkg::TolW-1:0];
    end
  end

  // register readback
  always_comb begin
    if (reg_sel == pssm_pkg::REG_SPAN_TOL) cfg_prdata = 32'(span_tol_r);
    else cfg_prdata = 32'(flat_tol_r);
  end

  pssm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .out_valid(out_valid), .out_ready(out_ready),
    .ctl(ctl), .sts(sts)
  );

  pssm_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_op(in_op), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_axis(in_axis), .span_tol(span_tol_r), .flat_tol(flat_tol_r),
    .out_midpoint(out_midpoint), .out_found(out_found),
    .out_inside_res(out_inside_res), .out_store_full(out_store_full)
  );
endmodule

// ----- tb/testbench.sv -----
// testbench for the polygon scanline span midpoint unit
`timescale 1ns / 1ps

module testbench;

  localparam int NVERT = 16;
  localparam int IDLE_LIMIT = 20000;   // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam logic [63:0] QMAX = 64'h100_0000_0000;

  typedef struct {
    logic signed [31:0] midpoint;
    logic               found;
    logic               inside_res;
    logic               store_full;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic               in_axis;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_midpoint;
  logic               out_found;
  logic               out_inside_res;
  logic               out_store_full;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // predictor state: our own copy of the polygon and the tolerances
  longint      poly_x [NVERT];
  longint      poly_y [NVERT];
  int          poly_n;
  logic [63:0] span_tol;
  logic [63:0] flat_tol;

  result_t     pending_q[$];
  int          fail_count;
  int          idle_cycles;
  bit          hold_req;

  polygon_scanline_span_midpoint_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_axis(in_axis),
    .out_valid(out_valid), .out_ready(out_ready), .out_midpoint(out_midpoint),
    .out_found(out_found), .out_inside_res(out_inside_res),
    .out_store_full(out_store_full),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // crossing of an edge with the scan key; quotient truncated, clamped to 2^40
  function automatic longint edge_crossing(longint key, longint k0, longint k1,
                                           longint d0, longint d1);
    longint      a;
    longint      b;
    longint      den;
    logic [63:0] q;
    bit          neg;
    a = key - k0;
    b = d1 - d0;
    den = k1 - k0;
    q = (magnitude(a) * magnitude(b)) / magnitude(den);
    neg = ((a < 0) != (b < 0)) != (den < 0);
    if (q > QMAX) q = QMAX;
    if (q == 0) neg = 1'b0;
    return neg ? d0 - longint'(q) : d0 + longint'(q);
  endfunction

  // midpoint of the span of crossings on the scan key
  function automatic result_t span_midpoint(longint px, longint py, logic axis);
    result_t r;
    longint  key, k0, k1, d0, d1, kmin, kmax, c_hi, c_lo, hi, lo, s, m;
    logic [63:0] dk;
    bit      any;
    int      p;
    r = '{default: 0};
    key = axis ? px : py;
    any = 0;
    hi = 0;
    lo = 0;
    for (int i = 0; i < poly_n; i++) begin
      p = (i == 0) ? poly_n - 1 : i - 1;
      k0 = axis ? poly_x[p] : poly_y[p];
      k1 = axis ? poly_x[i] : poly_y[i];
      d0 = axis ? poly_y[p] : poly_x[p];
      d1 = axis ? poly_y[i] : poly_x[i];
      kmin = (k0 < k1) ? k0 : k1;
      kmax = (k0 < k1) ? k1 : k0;
      if (key >= kmin - longint'(span_tol) && key <= kmax + longint'(span_tol)) begin
        dk = magnitude(k1 - k0);
        // flat edge: both endpoints join the crossing set
        if (dk == 0 || dk < flat_tol) begin
          c_hi = (d0 > d1) ? d0 : d1;
          c_lo = (d0 < d1) ? d0 : d1;
        end else begin
          c_hi = edge_crossing(key, k0, k1, d0, d1);
          c_lo = c_hi;
        end
        if (!any) begin
          hi = c_hi;
          lo = c_lo;
          any = 1;
        end else begin
          if (c_hi > hi) hi = c_hi;
          if (c_lo < lo) lo = c_lo;
        end
      end
    end
    if (any) begin
      s = hi + lo;
      m = s >>> 1;  // floor of half
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
      r.midpoint = m[31:0];
      r.found = 1'b1;
    end
    return r;
  endfunction

  // point is outside when strictly on the positive side of some edge normal (dy,-dx)
  function automatic bit convex_holds(longint px, longint py);
    logic signed [79:0] lhs;
    logic signed [79:0] rhs;
    int p;
    for (int i = 0; i < poly_n; i++) begin
      p = (i == 0) ? poly_n - 1 : i - 1;
      lhs = 80'(px - poly_x[p]) * 80'(poly_y[i] - poly_y[p]);
      rhs = 80'(py - poly_y[p]) * 80'(poly_x[i] - poly_x[p]);
      if (lhs > rhs) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected result of one word; updates the polygon state
  function automatic result_t polygon_step(pssm_pkg::op_t op, logic signed [31:0] x,
                                           logic signed [31:0] y, logic axis);
    result_t r;
    r = '{default: 0};
    case (op)
      pssm_pkg::OP_CLEAR: poly_n = 0;
      pssm_pkg::OP_APPEND: begin
        if (poly_n >= NVERT) r.store_full = 1'b1;
        else begin
          poly_x[poly_n] = x;
          poly_y[poly_n] = y;
          poly_n++;
        end
      end
      pssm_pkg::OP_QUERY: r = span_midpoint(x, y, axis);
      default: r.inside_res = convex_holds(x, y);
    endcase
    return r;
  endfunction

  // offer one word after a random gap; prediction taken at acceptance
  task automatic send_word(pssm_pkg::op_t op, logic signed [31:0] x,
                           logic signed [31:0] y, logic axis);
    int gap;
    int pick;
    result_t exp_r;
    pick = $urandom_range(0, 99);
    if (pick < 45) gap = 0;
    else if (pick < 93) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 120);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_coord_x <= x;
    in_coord_y <= y;
    in_axis    <= axis;
    do @(posedge clk); while (!in_ready);
    exp_r = polygon_step(op, x, y, axis);
    pending_q = {pending_q, exp_r};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // register write: setup then access cycle, block must be idle
  task automatic write_tol(logic [0:0] idx, logic [31:0] value);
    in_valid    <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == pssm_pkg::REG_SPAN_TOL) span_tol = 64'(value[24:0]);
    else flat_tol = 64'(value[24:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    else if (pick < 85) return $urandom;
    else if (pick < 92) return 32'sh7FFF_FFFF;
    else return 32'sh8000_0000;
  endfunction

  // convex polygon of three to eight vertices on an octagon, counterclockwise, around a random center
  task automatic build_octagon(int cx, int cy, int rad);
    int cs[8] = '{1000, 707, 0, -707, -1000, -707, 0, 707};
    int sn[8] = '{0, 707, 1000, 707, 0, -707, -1000, -707};
    int nv;
    nv = $urandom_range(3, 8);
    send_word(pssm_pkg::OP_CLEAR, $urandom, $urandom, $urandom_range(0, 1));
    for (int i = 0; i < nv; i++)
      send_word(pssm_pkg::OP_APPEND, cx + (rad / 1000) * cs[i * 8 / nv],
                cy + (rad / 1000) * sn[i * 8 / nv], $urandom_range(0, 1));
  endtask

  task automatic test_directed();
    // empty polygon: no crossing, and the convex test passes
    send_word(pssm_pkg::OP_CLEAR, 0, 0, 0);
    send_word(pssm_pkg::OP_QUERY, 0, 0, 0);
    send_word(pssm_pkg::OP_CONVEX, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    // unit square, counterclockwise
    send_word(pssm_pkg::OP_APPEND, 0, 0, 0);
    send_word(pssm_pkg::OP_APPEND, 32'sh0100_0000, 0, 1);
    send_word(pssm_pkg::OP_APPEND, 32'sh0100_0000, 32'sh0100_0000, 0);
    send_word(pssm_pkg::OP_APPEND, 0, 32'sh0100_0000, 1);
    send_word(pssm_pkg::OP_QUERY, 0, 32'sh0080_0000, 0);
    send_word(pssm_pkg::OP_QUERY, 32'sh0040_0000, 0, 1);
    send_word(pssm_pkg::OP_QUERY, 0, 32'sh0300_0000, 0);        // key misses every edge
    send_word(pssm_pkg::OP_QUERY, 0, 0, 0);                     // key on a flat edge
    send_word(pssm_pkg::OP_CONVEX, 32'sh0080_0000, 32'sh0080_0000, 0);
    send_word(pssm_pkg::OP_CONVEX, 32'sh0100_0000, 32'sh0080_0000, 0);  // on an edge
    send_word(pssm_pkg::OP_CONVEX, 32'sh0200_0000, 32'sh0080_0000, 1);
    // extreme corners: clamped quotient and saturated midpoint
    send_word(pssm_pkg::OP_CLEAR, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_word(pssm_pkg::OP_APPEND, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_word(pssm_pkg::OP_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_word(pssm_pkg::OP_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_word(pssm_pkg::OP_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_word(pssm_pkg::OP_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    send_word(pssm_pkg::OP_CONVEX, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    // fill the store then overflow it
    for (int i = 0; i < NVERT - 3 + 2; i++)
      send_word(pssm_pkg::OP_APPEND, rand_coord(), rand_coord(), 0);
    send_word(pssm_pkg::OP_QUERY, rand_coord(), rand_coord(), 1);
    wait_drained();
  endtask

  task automatic test_random(int n_items);
    int sent;
    int nv;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise: any op with any fields
        send_word(pssm_pkg::op_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                  $urandom_range(0, 1));
        sent++;
      end else if (pick < 45) begin
        build_octagon($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000,
                      $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000,
                      $urandom_range(1000, 32'h0100_0000));
        sent += 9;
        repeat ($urandom_range(2, 6)) begin
          send_word(pssm_pkg::op_t'($urandom_range(pssm_pkg::OP_QUERY,
                                                   pssm_pkg::OP_CONVEX)),
                    $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000,
                    $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000,
                    $urandom_range(0, 1));
          sent++;
        end
      end else begin
        // arbitrary polygon, mostly small, sometimes overfilled
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
        send_word(pssm_pkg::OP_CLEAR, rand_coord(), rand_coord(), $urandom_range(0, 1));
        for (int i = 0; i < nv; i++)
          send_word(pssm_pkg::OP_APPEND, rand_coord(), rand_coord(),
                    $urandom_range(0, 1));
        sent += nv + 1;
        repeat ($urandom_range(1, 5)) begin
          send_word(pssm_pkg::op_t'($urandom_range(pssm_pkg::OP_QUERY,
                                                   pssm_pkg::OP_CONVEX)),
                    rand_coord(), rand_coord(), $urandom_range(0, 1));
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_word(pssm_pkg::op_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                $urandom_range(0, 1));
    wait_drained();
  endtask

  task automatic test_tolerances();
    logic [31:0] vals[6] = '{32'd0, 32'h0100_0000, 32'h01FF_FFFF, 32'hFFFF_FFFF,
                             32'd1, 32'h0000_4000};
    for (int i = 0; i < 6; i++) begin
      write_tol(pssm_pkg::REG_SPAN_TOL, vals[i]);
      write_tol(pssm_pkg::REG_FLAT_TOL, vals[(i + 3) % 6]);
      test_random(40);
    end
    write_tol(pssm_pkg::REG_SPAN_TOL, 32'd17);
    write_tol(pssm_pkg::REG_FLAT_TOL, 32'd17);
  endtask

  // receiver: short and long stalls, plus one requested long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  // result checker: compare each word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word mid=%0d found=%0b inside=%0b full=%0b",
                 $time, out_midpoint, out_found, out_inside_res, out_store_full);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_midpoint !== want.midpoint) begin
          $display("%0t: midpoint exp %0d got %0d", $time, want.midpoint, out_midpoint);
          fail_count++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found exp %0b got %0b", $time, want.found, out_found);
          fail_count++;
        end
        if (out_inside_res !== want.inside_res) begin
          $display("%0t: inside_res exp %0b got %0b", $time, want.inside_res,
                   out_inside_res);
          fail_count++;
        end
        if (out_store_full !== want.store_full) begin
          $display("%0t: store_full exp %0b got %0b", $time, want.store_full,
                   out_store_full);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    poly_n = 0;
    span_tol = 64'd17;
    flat_tol = 64'd17;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = pssm_pkg::OP_CLEAR;
    in_coord_x = '0;
    in_coord_y = '0;
    in_axis = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_tolerances();
    test_random(270);

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- polygon_scanline_span_midpoint_unit.f -----
sv/pssm_pkg.sv
sv/pssm_div.sv
sv/pssm_ctrl.sv
sv/pssm_dp.sv
sv/polygon_scanline_span_midpoint_unit.sv
tb/testbench.sv
